FILE: src/ruf_pkg.sv
// Package for the rollback union-find block.
// Holds the request and result types, mode and undo-entry codes, and the
// command and status structs between the controller and the datapath.
package ruf_pkg;

  localparam int NODES_DEF = 64;
  localparam int STACK_DEPTH_DEF = 256;

  localparam int MODE_W = 2;
  localparam int NODE_IN_W = 6;
  localparam int ROOT_W = 6;
  localparam int COUNT_W = 7;
  localparam int KIND_W = 2;

  localparam logic [MODE_W-1:0] MODE_UNITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SNAP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ROLL = 2'd3;

  localparam logic [KIND_W-1:0] KIND_MERGE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOOP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MARK = 2'd2;

  // Parent memory read address selects.
  localparam logic [1:0] PRD_NA = 2'd0;
  localparam logic [1:0] PRD_NB = 2'd1;
  localparam logic [1:0] PRD_WALK = 2'd2;
  localparam logic [1:0] PRD_STK = 2'd3;

  // Size memory read address selects.
  localparam logic SRD_A = 1'b0;
  localparam logic SRD_B = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [NODE_IN_W-1:0] node_a;
    logic [NODE_IN_W-1:0] node_b;
  } req_t;

  typedef struct packed {
    logic answer_flag;
    logic [ROOT_W-1:0] root_found;
    logic [COUNT_W-1:0] component_total;
    logic status;
  } rsp_t;

  typedef struct packed {
    logic idle;
    logic load;
    logic res_clear;
    logic par_re;
    logic [1:0] par_rsel;
    logic root_a_we;
    logic root_b_we;
    logic sz_re;
    logic sz_rsel;
    logic size_a_we;
    logic push;
    logic [KIND_W-1:0] push_kind;
    logic merge;
    logic pop;
    logic undo;
    logic res_query;
    logic res_unite;
    logic res_full;
    logic clr;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic par_hit;
    logic roots_eq;
    logic sp_full;
    logic sp_empty;
    logic [KIND_W-1:0] stk_kind;
    logic clr_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

FILE: src/ruf_datapath.sv
// Datapath of the rollback union-find block: parent, size and undo-stack
// memories, walk and merge logic, and the result register.
// Depends on ruf_pkg; driven by ruf_ctrl through ctrl_cmd_t.
module ruf_datapath
  import ruf_pkg::*;
#(
  parameter int NODES = NODES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       req_data,
  input  logic       rsp_stall,
  output logic       rsp_valid,
  output rsp_t       rsp_data,
  input  ctrl_cmd_t  cmd,
  output ctrl_stat_t stat
);

  localparam int NW = $clog2(NODES);
  localparam int SW = $clog2(NODES + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam int IN_SPAN = 2 ** NODE_IN_W;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NW-1:0] node;
    logic [SW-1:0] old_size;
  } entry_t;

  logic [NW-1:0] parent_mem [NODES];
  logic [SW-1:0] size_mem [NODES];
  entry_t stack_mem [STACK_DEPTH];

  logic [NW-1:0] par_q;
  logic [SW-1:0] size_q;
  entry_t stk_q;

  logic [MODE_W-1:0] mode;
  logic [NW-1:0] na;
  logic [NW-1:0] nb;
  logic [NW-1:0] cur;
  logic [NW-1:0] root_a;
  logic [NW-1:0] root_b;
  logic [SW-1:0] size_a;
  logic [SW-1:0] count;
  logic [PW-1:0] sp;
  logic [NW-1:0] clr_idx;
  logic res_flag;
  logic [ROOT_W-1:0] res_root;
  logic res_status;

  logic [NW-1:0] mod_tab [IN_SPAN];
  logic [NW-1:0] par_raddr;
  logic [NW-1:0] sz_raddr;
  logic [AW-1:0] stk_raddr;
  logic a_small;
  logic [NW-1:0] big;
  logic [NW-1:0] small_root;
  logic [SW-1:0] size_big;
  logic [SW-1:0] size_sum;
  logic par_we;
  logic [NW-1:0] par_waddr;
  logic [NW-1:0] par_wdata;
  logic size_we;
  logic [NW-1:0] size_waddr;
  logic [SW-1:0] size_wdata;
  logic stk_we;
  entry_t stk_wdata;

  for (genvar i = 0; i < IN_SPAN; i++) begin : g_mod
    assign mod_tab[i] = NW'(i % NODES);
  end

  always_comb begin
    unique case (cmd.par_rsel)
      PRD_NA: par_raddr = na;
      PRD_NB: par_raddr = nb;
      PRD_WALK: par_raddr = par_q;
      PRD_STK: par_raddr = stk_q.node;
      default: par_raddr = na;
    endcase
  end

  assign sz_raddr = (cmd.sz_rsel == SRD_B) ? root_b : root_a;
  assign stk_raddr = AW'(sp - PW'(1));

  assign a_small = size_a < size_q;
  assign big = a_small ? root_b : root_a;
  assign small_root = a_small ? root_a : root_b;
  assign size_big = a_small ? size_q : size_a;
  assign size_sum = size_a + size_q;

  always_comb begin
    par_we = 1'b1;
    size_we = 1'b1;
    priority if (cmd.clr) begin
      par_waddr = clr_idx;
      par_wdata = clr_idx;
      size_waddr = clr_idx;
      size_wdata = SW'(1);
    end else if (cmd.merge) begin
      par_waddr = small_root;
      par_wdata = big;
      size_waddr = big;
      size_wdata = size_sum;
    end else if (cmd.undo) begin
      par_waddr = cur;
      par_wdata = cur;
      size_waddr = par_q;
      size_wdata = stk_q.old_size;
    end else begin
      par_we = 1'b0;
      size_we = 1'b0;
      par_waddr = cur;
      par_wdata = cur;
      size_waddr = cur;
      size_wdata = stk_q.old_size;
    end
  end

  assign stk_we = cmd.push || cmd.merge;

  always_comb begin
    if (cmd.merge) begin
      stk_wdata = '{kind: KIND_MERGE, node: small_root, old_size: size_big};
    end else begin
      stk_wdata = '{kind: cmd.push_kind, node: '0, old_size: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      parent_mem[par_waddr] <= par_wdata;
    end
    if (cmd.par_re) begin
      par_q <= parent_mem[par_raddr];
    end
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    if (cmd.sz_re) begin
      size_q <= size_mem[sz_raddr];
    end
    if (stk_we) begin
      stack_mem[sp[AW-1:0]] <= stk_wdata;
    end
    if (cmd.pop) begin
      stk_q <= stack_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
      count <= SW'(NODES);
      clr_idx <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_idx <= clr_idx + NW'(1);
      end
      if (cmd.merge) begin
        count <= count - SW'(1);
      end else if (cmd.undo) begin
        count <= count + SW'(1);
      end
      if (stk_we) begin
        sp <= sp + PW'(1);
      end else if (cmd.pop) begin
        sp <= sp - PW'(1);
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= req_data.mode;
      na <= mod_tab[req_data.node_a];
      nb <= mod_tab[req_data.node_b];
    end
    if (cmd.par_re) begin
      cur <= par_raddr;
    end
    if (cmd.root_a_we) begin
      root_a <= cur;
    end
    if (cmd.root_b_we) begin
      root_b <= cur;
    end
    if (cmd.size_a_we) begin
      size_a <= size_q;
    end
    if (cmd.res_clear) begin
      res_flag <= 1'b0;
      res_root <= '0;
      res_status <= 1'b0;
    end
    if (cmd.res_query) begin
      res_flag <= stat.roots_eq;
      res_root <= ROOT_W'(root_a);
    end
    if (cmd.res_unite) begin
      res_root <= ROOT_W'(root_a);
    end
    if (cmd.res_full) begin
      res_status <= 1'b1;
    end
    if (cmd.merge) begin
      res_flag <= 1'b1;
    end
    if (cmd.out_load) begin
      rsp_data <= '{answer_flag: res_flag, root_found: res_root,
                    component_total: COUNT_W'(count), status: res_status};
    end
  end

  assign stat.mode = mode;
  assign stat.par_hit = par_q == cur;
  assign stat.roots_eq = root_a == cur;
  assign stat.sp_full = sp == PW'(STACK_DEPTH);
  assign stat.sp_empty = sp == '0;
  assign stat.stk_kind = stk_q.kind;
  assign stat.clr_last = clr_idx == NW'(NODES - 1);
  assign stat.out_free = !rsp_valid || !rsp_stall;

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= PW'(STACK_DEPTH))
    else $error("Undo stack pointer passed the stack depth.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= SW'(NODES))
    else $error("Component count left its valid range.");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    stk_we |-> !stat.sp_full)
    else $error("Push onto a full undo stack.");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.sp_empty)
    else $error("Pop from an empty undo stack.");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> $past(1'b1) && (!rsp_valid || !rsp_stall))
    else $error("Result register overwritten while still held.");
`endif

endmodule

FILE: src/ruf_ctrl.sv
// Controller state machine of the rollback union-find block.
// Depends on ruf_pkg; sequences ruf_datapath through ctrl_cmd_t and ctrl_stat_t.
module ruf_ctrl
  import ruf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_START = 4'd2;
  localparam logic [3:0] ST_FIND_A = 4'd3;
  localparam logic [3:0] ST_FIND_B = 4'd4;
  localparam logic [3:0] ST_SZ_A = 4'd5;
  localparam logic [3:0] ST_SZ_B = 4'd6;
  localparam logic [3:0] ST_POP = 4'd7;
  localparam logic [3:0] ST_UNDO = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.res_clear = 1'b1;
        unique case (stat.mode)
          MODE_UNITE, MODE_QUERY: begin
            cmd.par_re = 1'b1;
            cmd.par_rsel = PRD_NA;
            state_next = ST_FIND_A;
          end
          MODE_SNAP: begin
            if (stat.sp_full) begin
              cmd.res_full = 1'b1;
            end else begin
              cmd.push = 1'b1;
              cmd.push_kind = KIND_MARK;
            end
            state_next = ST_DONE;
          end
          MODE_ROLL: begin
            if (stat.sp_empty) begin
              state_next = ST_DONE;
            end else begin
              cmd.pop = 1'b1;
              state_next = ST_POP;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_FIND_A: begin
        cmd.par_re = 1'b1;
        if (stat.par_hit) begin
          cmd.root_a_we = 1'b1;
          cmd.par_rsel = PRD_NB;
          state_next = ST_FIND_B;
        end else begin
          cmd.par_rsel = PRD_WALK;
        end
      end
      ST_FIND_B: begin
        if (stat.par_hit) begin
          cmd.root_b_we = 1'b1;
          if (stat.mode == MODE_QUERY) begin
            cmd.res_query = 1'b1;
            state_next = ST_DONE;
          end else begin
            cmd.res_unite = 1'b1;
            priority if (stat.sp_full) begin
              cmd.res_full = 1'b1;
              state_next = ST_DONE;
            end else if (stat.roots_eq) begin
              cmd.push = 1'b1;
              cmd.push_kind = KIND_NOOP;
              state_next = ST_DONE;
            end else begin
              cmd.sz_re = 1'b1;
              cmd.sz_rsel = SRD_A;
              state_next = ST_SZ_A;
            end
          end
        end else begin
          cmd.par_re = 1'b1;
          cmd.par_rsel = PRD_WALK;
        end
      end
      ST_SZ_A: begin
        cmd.size_a_we = 1'b1;
        cmd.sz_re = 1'b1;
        cmd.sz_rsel = SRD_B;
        state_next = ST_SZ_B;
      end
      ST_SZ_B: begin
        cmd.merge = 1'b1;
        state_next = ST_DONE;
      end
      ST_POP: begin
        priority if (stat.stk_kind == KIND_MARK) begin
          state_next = ST_DONE;
        end else if (stat.stk_kind == KIND_NOOP) begin
          if (stat.sp_empty) begin
            state_next = ST_DONE;
          end else begin
            cmd.pop = 1'b1;
          end
        end else begin
          cmd.par_re = 1'b1;
          cmd.par_rsel = PRD_STK;
          state_next = ST_UNDO;
        end
      end
      ST_UNDO: begin
        cmd.undo = 1'b1;
        if (stat.sp_empty) begin
          state_next = ST_DONE;
        end else begin
          cmd.pop = 1'b1;
          state_next = ST_POP;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/rollback_union_find.sv
// Top level of the rollback union-find block: a disjoint-set store with
// union by size and an undo stack. Instantiates ruf_ctrl and ruf_datapath.
// Depends on ruf_pkg.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  req_data (req_t)
//   rsp      out        rsp_valid / rsp_stall  rsp_data (rsp_t)
//
// One request is worked at a time. A unite or query walks the parent links from each of
// its two nodes to the root, with one parent memory read per cycle; each parent-link depth
// is at most log2(NODES). A merge first reads the sizes of both roots. A rollback pops
// undo entries one at a time, and spends an extra step on each merge that it undoes.
// After reset a clearing pass sets up the parent and size
// memories, and req_stall stays high until it ends.
// A finished result waits in the output register while rsp_stall is high.
module rollback_union_find
  import ruf_pkg::*;
#(
  parameter int NODES = NODES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  ctrl_cmd_t cmd;
  ctrl_stat_t stat;

  ruf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  ruf_datapath #(
    .NODES       (NODES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign req_stall = !cmd.idle;

endmodule
